// File: src/sfp_pkg.sv
package sfp_pkg;

  localparam int SFP_FIELD_CHARS = 6;
  localparam int TEXT_W          = 48;
  localparam int POINT_W         = 4;
  localparam int SUM_W           = 7;

  localparam logic [7:0] CHAR_STX   = 8'h02;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_CR    = 8'h0D;

  localparam logic [7:0] STAT_A_POINT_MASK = 8'b0000_0111;
  localparam logic [7:0] STAT_B_ERR_MASK   = 8'b0000_0110;
  localparam logic [7:0] STAT_B_NET_MASK   = 8'b0000_0001;
  localparam logic [7:0] STAT_B_KG_MASK    = 8'b0001_0000;

  localparam logic [POINT_W-1:0] POINT_BASE = 4'd8;

endpackage

// File: src/sfp_if.sv
interface sfp_in_if import sfp_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfp_out_if import sfp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [TEXT_W-1:0]  weight_text;
  logic [TEXT_W-1:0]  tare_text;
  logic [POINT_W-1:0] point_position;
  logic               unit_kg;
  logic               net_flag;
  logic               checksum_ok;
  logic               weight_changed;
  logic               tare_changed;
  logic               unit_changed;
  logic               net_changed;

  modport source (
    output valid, output weight_text, output tare_text, output point_position,
    output unit_kg, output net_flag, output checksum_ok, output weight_changed,
    output tare_changed, output unit_changed, output net_changed, input ready
  );
  modport sink (
    input valid, input weight_text, input tare_text, input point_position,
    input unit_kg, input net_flag, input checksum_ok, input weight_changed,
    input tare_changed, input unit_changed, input net_changed, output ready
  );
endinterface

// File: src/scale_frame_parser.sv
// Continuous-output scale frame decoder. Takes one serial byte per word on in_rx and
// ignores bytes until STX; then reads status A, B, C, FIELD_CHARS weight and FIELD_CHARS
// tare characters (space stored as '0'), CR and a checksum byte. On the checksum byte one
// result word appears on out_res the next cycle, with checksum_ok set when the 7-bit sum
// of all frame bytes is zero and changed flags against the last good frame. A status B
// error (bit 1 or 2) or a missing CR drops the frame silently. A byte can be accepted each
// cycle; only a checksum byte waits, and only while the single result register still holds
// a word the sink has not taken.
module scale_frame_parser import sfp_pkg::*; #(
  parameter int FIELD_CHARS = SFP_FIELD_CHARS
) (
  input  logic      clk,
  input  logic      rst_n,
  sfp_in_if.sink    in_rx,
  sfp_out_if.source out_res
);

  localparam int CNT_W = (FIELD_CHARS > 1) ? $clog2(FIELD_CHARS) : 1;

  typedef enum logic [2:0] {
    PH_WAIT, PH_STAT_A, PH_STAT_B, PH_STAT_C, PH_WEIGHT, PH_TARE, PH_CR, PH_CHECK
  } phase_t;

  phase_t             phase_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [SUM_W-1:0]   sum_r;
  logic [POINT_W-1:0] point_r;
  logic               unit_r;
  logic               net_r;
  logic [TEXT_W-1:0]  wbuf_r;
  logic [TEXT_W-1:0]  tbuf_r;
  logic [TEXT_W-1:0]  pub_weight_r;
  logic [TEXT_W-1:0]  pub_tare_r;
  logic               pub_unit_r;
  logic               pub_net_r;
  logic               pub_valid_r;

  logic               out_valid_r;
  logic               out_valid_nxt;
  logic [TEXT_W-1:0]  out_weight_r;
  logic [TEXT_W-1:0]  out_tare_r;
  logic [POINT_W-1:0] out_point_r;
  logic               out_unit_r;
  logic               out_net_r;
  logic               out_ok_r;
  logic               out_wc_r;
  logic               out_tc_r;
  logic               out_uc_r;
  logic               out_nc_r;

  logic               in_fire;
  logic               out_free;
  logic [7:0]         b;
  logic [SUM_W-1:0]   sum_nxt;
  logic [7:0]         char_nxt;
  logic [CNT_W:0]     cnt_inc;
  logic               field_done;
  logic               sum_ok;
  logic               fresh;

  assign out_free    = !out_valid_r || out_res.ready;
  assign in_rx.ready = out_free || (phase_r != PH_CHECK);
  assign in_fire     = in_rx.valid && in_rx.ready;
  assign b           = in_rx.rx_byte;

  assign out_valid_nxt = (in_fire && (phase_r == PH_CHECK)) ||
                         (out_valid_r && !out_res.ready);

  assign sum_nxt    = sum_r + b[SUM_W-1:0];
  assign char_nxt   = (b == CHAR_SPACE) ? CHAR_ZERO : b;
  assign cnt_inc    = {1'b0, cnt_r} + (CNT_W+1)'(1);
  assign field_done = (cnt_inc >= (CNT_W+1)'(FIELD_CHARS));
  assign sum_ok     = (sum_nxt == '0);
  assign fresh      = !pub_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_WAIT;
      cnt_r       <= '0;
      sum_r       <= '0;
      pub_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        unique case (phase_r)
          PH_WAIT: begin
            if (b == CHAR_STX) begin
              sum_r   <= b[SUM_W-1:0];
              cnt_r   <= '0;
              unit_r  <= 1'b0;
              net_r   <= 1'b0;
              wbuf_r  <= '0;
              tbuf_r  <= '0;
              phase_r <= PH_STAT_A;
            end
          end
          PH_STAT_A: begin
            sum_r   <= sum_nxt;
            point_r <= POINT_BASE - POINT_W'(b & STAT_A_POINT_MASK);
            phase_r <= PH_STAT_B;
          end
          PH_STAT_B: begin
            sum_r <= sum_nxt;
            if ((b & STAT_B_ERR_MASK) != '0) begin
              phase_r <= PH_WAIT;
            end else begin
              net_r   <= |(b & STAT_B_NET_MASK);
              unit_r  <= |(b & STAT_B_KG_MASK);
              phase_r <= PH_STAT_C;
            end
          end
          PH_STAT_C: begin
            sum_r   <= sum_nxt;
            cnt_r   <= '0;
            phase_r <= PH_WEIGHT;
          end
          PH_WEIGHT: begin
            sum_r  <= sum_nxt;
            wbuf_r <= {wbuf_r[TEXT_W-9:0], char_nxt};
            if (field_done) begin
              cnt_r   <= '0;
              phase_r <= PH_TARE;
            end else begin
              cnt_r <= cnt_inc[CNT_W-1:0];
            end
          end
          PH_TARE: begin
            sum_r  <= sum_nxt;
            tbuf_r <= {tbuf_r[TEXT_W-9:0], char_nxt};
            if (field_done) begin
              cnt_r   <= '0;
              phase_r <= PH_CR;
            end else begin
              cnt_r <= cnt_inc[CNT_W-1:0];
            end
          end
          PH_CR: begin
            sum_r   <= sum_nxt;
            phase_r <= (b == CHAR_CR) ? PH_CHECK : PH_WAIT;
          end
          PH_CHECK: begin
            sum_r        <= sum_nxt;
            phase_r      <= PH_WAIT;
            out_weight_r <= wbuf_r;
            out_tare_r   <= tbuf_r;
            out_point_r  <= point_r;
            out_unit_r   <= unit_r;
            out_net_r    <= net_r;
            out_ok_r     <= sum_ok;
            out_wc_r     <= sum_ok && (fresh || (wbuf_r != pub_weight_r));
            out_tc_r     <= sum_ok && (fresh || (tbuf_r != pub_tare_r));
            out_uc_r     <= sum_ok && (fresh || (unit_r != pub_unit_r));
            out_nc_r     <= sum_ok && (fresh || (net_r != pub_net_r));
            if (sum_ok) begin
              pub_weight_r <= wbuf_r;
              pub_tare_r   <= tbuf_r;
              pub_unit_r   <= unit_r;
              pub_net_r    <= net_r;
              pub_valid_r  <= 1'b1;
            end
          end
          default: begin
            phase_r <= PH_WAIT;
          end
        endcase
      end
    end
  end

  assign out_res.valid          = out_valid_r;
  assign out_res.weight_text    = out_weight_r;
  assign out_res.tare_text      = out_tare_r;
  assign out_res.point_position = out_point_r;
  assign out_res.unit_kg        = out_unit_r;
  assign out_res.net_flag       = out_net_r;
  assign out_res.checksum_ok    = out_ok_r;
  assign out_res.weight_changed = out_wc_r;
  assign out_res.tare_changed   = out_tc_r;
  assign out_res.unit_changed   = out_uc_r;
  assign out_res.net_changed    = out_nc_r;

`ifndef SYNTHESIS
  a_check_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (phase_r == PH_CHECK)) |=> out_valid_r)
    else $error("checksum word did not produce a result");

  a_changed_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_wc_r || out_tc_r || out_uc_r || out_nc_r)) |-> out_ok_r)
    else $error("changed flag set on a bad frame");

  a_publish: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (phase_r == PH_CHECK) && sum_ok) |=> pub_valid_r)
    else $error("good frame not published");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, cnt_r} < (CNT_W+1)'(FIELD_CHARS)))
    else $error("character count out of range");

  a_hold_check: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_res.ready && (phase_r == PH_CHECK)) |-> !in_rx.ready)
    else $error("checksum word taken while result stalled");
`endif

endmodule

// File: tb/sfp_frame_checker.sv
`timescale 1ns / 100ps

module sfp_frame_checker import sfp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  sfp_in_if    rx_mon,
  sfp_out_if   res_mon,
  output int   fail_count,
  output int   pending_count,
  output int   good_count
);

  localparam int FIELD_CHARS = SFP_FIELD_CHARS;

  typedef enum logic [2:0] {
    WAIT_STX, STAT_A, STAT_B, STAT_C, WEIGHT, TARE, CR_SLOT, CHECK_SLOT
  } frame_phase_t;

  typedef struct packed {
    logic [TEXT_W-1:0]  weight_text;
    logic [TEXT_W-1:0]  tare_text;
    logic [POINT_W-1:0] point_position;
    logic               unit_kg;
    logic               net_flag;
    logic               checksum_ok;
    logic               weight_changed;
    logic               tare_changed;
    logic               unit_changed;
    logic               net_changed;
  } scale_reading_t;

  frame_phase_t       phase;
  logic [2:0]         char_idx;
  logic [SUM_W-1:0]   frame_sum;
  logic [POINT_W-1:0] point_idx;
  logic               frame_kg;
  logic               frame_net;
  logic [TEXT_W-1:0]  weight_acc;
  logic [TEXT_W-1:0]  tare_acc;
  logic [TEXT_W-1:0]  pub_weight;
  logic [TEXT_W-1:0]  pub_tare;
  logic               pub_kg;
  logic               pub_net;
  logic               pub_valid;
  scale_reading_t     readings_due[$];

  task automatic decode_scale_byte(input logic [7:0] b);
    logic [SUM_W-1:0] sum_next;
    logic [7:0]       stored;
    logic             good;
    scale_reading_t   r;
    sum_next = frame_sum + b[SUM_W-1:0];
    stored = (b == CHAR_SPACE) ? CHAR_ZERO : b;
    case (phase)
      WAIT_STX: begin
        if (b == CHAR_STX) begin
          frame_sum  = b[SUM_W-1:0];
          char_idx   = '0;
          frame_kg   = 1'b0;
          frame_net  = 1'b0;
          weight_acc = '0;
          tare_acc   = '0;
          phase      = STAT_A;
        end
      end
      STAT_A: begin
        frame_sum = sum_next;
        point_idx = POINT_BASE - POINT_W'(b & STAT_A_POINT_MASK);
        phase     = STAT_B;
      end
      STAT_B: begin
        frame_sum = sum_next;
        if ((b & STAT_B_ERR_MASK) != 8'h00) begin
          phase = WAIT_STX;
        end else begin
          frame_net = |(b & STAT_B_NET_MASK);
          frame_kg  = |(b & STAT_B_KG_MASK);
          phase     = STAT_C;
        end
      end
      STAT_C: begin
        frame_sum = sum_next;
        char_idx  = '0;
        phase     = WEIGHT;
      end
      WEIGHT: begin
        frame_sum  = sum_next;
        weight_acc = {weight_acc[TEXT_W-9:0], stored};
        if (char_idx + 1 >= FIELD_CHARS) begin
          char_idx = '0;
          phase    = TARE;
        end else begin
          char_idx = char_idx + 3'd1;
        end
      end
      TARE: begin
        frame_sum = sum_next;
        tare_acc  = {tare_acc[TEXT_W-9:0], stored};
        if (char_idx + 1 >= FIELD_CHARS) begin
          char_idx = '0;
          phase    = CR_SLOT;
        end else begin
          char_idx = char_idx + 3'd1;
        end
      end
      CR_SLOT: begin
        frame_sum = sum_next;
        phase = (b == CHAR_CR) ? CHECK_SLOT : WAIT_STX;
      end
      CHECK_SLOT: begin
        good      = (sum_next == '0);
        frame_sum = sum_next;
        phase     = WAIT_STX;
        r = '0;
        r.weight_text    = weight_acc;
        r.tare_text      = tare_acc;
        r.point_position = point_idx;
        r.unit_kg        = frame_kg;
        r.net_flag       = frame_net;
        r.checksum_ok    = good;
        if (good) begin
          r.weight_changed = !pub_valid || (weight_acc != pub_weight);
          r.tare_changed   = !pub_valid || (tare_acc != pub_tare);
          r.unit_changed   = !pub_valid || (frame_kg != pub_kg);
          r.net_changed    = !pub_valid || (frame_net != pub_net);
          pub_weight = weight_acc;
          pub_tare   = tare_acc;
          pub_kg     = frame_kg;
          pub_net    = frame_net;
          pub_valid  = 1'b1;
        end
        readings_due.push_back(r);
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [TEXT_W-1:0] want,
                             input logic [TEXT_W-1:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %h got %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    scale_reading_t got;
    scale_reading_t want;
    if (!rst_n) begin
      phase      = WAIT_STX;
      char_idx   = '0;
      frame_sum  = '0;
      point_idx  = '0;
      frame_kg   = 1'b0;
      frame_net  = 1'b0;
      weight_acc = '0;
      tare_acc   = '0;
      pub_weight = '0;
      pub_tare   = '0;
      pub_kg     = 1'b0;
      pub_net    = 1'b0;
      pub_valid  = 1'b0;
      readings_due.delete();
      fail_count = 0;
      good_count = 0;
    end else begin
      if (rx_mon.valid && rx_mon.ready) begin
        decode_scale_byte(rx_mon.rx_byte);
      end
      if (res_mon.valid && res_mon.ready) begin
        got.weight_text    = res_mon.weight_text;
        got.tare_text      = res_mon.tare_text;
        got.point_position = res_mon.point_position;
        got.unit_kg        = res_mon.unit_kg;
        got.net_flag       = res_mon.net_flag;
        got.checksum_ok    = res_mon.checksum_ok;
        got.weight_changed = res_mon.weight_changed;
        got.tare_changed   = res_mon.tare_changed;
        got.unit_changed   = res_mon.unit_changed;
        got.net_changed    = res_mon.net_changed;
        if (readings_due.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result word, expected none got %h", $time, got);
        end else begin
          want = readings_due.pop_front();
          if (want.checksum_ok) good_count++;
          check_field("weight_text", want.weight_text, got.weight_text);
          check_field("tare_text", want.tare_text, got.tare_text);
          check_field("point_position", want.point_position, got.point_position);
          check_field("unit_kg", want.unit_kg, got.unit_kg);
          check_field("net_flag", want.net_flag, got.net_flag);
          check_field("checksum_ok", want.checksum_ok, got.checksum_ok);
          check_field("weight_changed", want.weight_changed, got.weight_changed);
          check_field("tare_changed", want.tare_changed, got.tare_changed);
          check_field("unit_changed", want.unit_changed, got.unit_changed);
          check_field("net_changed", want.net_changed, got.net_changed);
        end
      end
    end
    pending_count = readings_due.size();
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import sfp_pkg::*;

  localparam int ITEMS       = 700;
  localparam int LIMIT       = 200000;
  localparam int LONG_HOLD   = 400;
  localparam int TAIL        = 20;

  typedef enum int {
    FRAME_GOOD, FRAME_REPEAT, FRAME_BAD_SUM, FRAME_STATUS_ERR, FRAME_NO_CR
  } frame_kind_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  sfp_in_if  in_rx ();
  sfp_out_if out_res ();

  int fail_count;
  int pending_count;
  int good_count;
  int bytes_sent    = 0;
  int results_seen  = 0;
  int burst_left    = 0;
  int cycle_count   = 0;
  int kind_count[5] = '{0, 0, 0, 0, 0};
  logic steady        = 1'b0;
  logic long_hold_req = 1'b0;
  logic [7:0] frame_body[$];
  logic [7:0] prev_body[$];

  scale_frame_parser dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_rx   (in_rx),
    .out_res (out_res)
  );

  sfp_frame_checker frame_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .rx_mon        (in_rx),
    .res_mon       (out_res),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .good_count    (good_count)
  );

  always #5 clk = ~clk;

  function automatic logic [7:0] pick_char();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 6) return 8'h30 + 8'($urandom_range(0, 9));
    if (roll < 8) return CHAR_SPACE;
    if (roll == 8) return 8'h2E;
    return 8'($urandom);
  endfunction

  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    b = 8'($urandom);
    if (b == CHAR_STX && $urandom_range(0, 3) != 0) b = 8'h00;
    return b;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0 && !steady) begin
        in_rx.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_rx.valid   <= 1'b1;
    in_rx.rx_byte <= b;
    do @(posedge clk); while (!in_rx.ready);
    bytes_sent++;
  endtask

  task automatic drain();
    in_rx.valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  task automatic make_random_body(input logic status_err);
    logic [7:0] stat_b;
    int extra;
    frame_body.delete();
    stat_b = 8'($urandom);
    if (status_err) stat_b = stat_b | (8'($urandom_range(1, 3)) << 1);
    else stat_b = stat_b & ~STAT_B_ERR_MASK;
    frame_body.push_back(8'($urandom));
    frame_body.push_back(stat_b);
    frame_body.push_back(8'($urandom));
    extra = status_err ? $urandom_range(0, 4) : 2 * SFP_FIELD_CHARS;
    repeat (extra) frame_body.push_back(pick_char());
  endtask

  task automatic make_repeat_body();
    int pos;
    frame_body = prev_body;
    if ($urandom_range(0, 1) == 1) begin
      pos = $urandom_range(2, 2 + 2 * SFP_FIELD_CHARS);
      if (pos == 2) begin
        frame_body[1] = frame_body[1] ^
          (($urandom_range(0, 1) == 1) ? STAT_B_NET_MASK : STAT_B_KG_MASK);
      end else begin
        frame_body[pos] = pick_char();
      end
    end
  endtask

  task automatic transmit(input frame_kind_t kind);
    logic [SUM_W-1:0] sum;
    logic [7:0] cr;
    sum = CHAR_STX[SUM_W-1:0];
    send_byte(CHAR_STX);
    foreach (frame_body[i]) begin
      sum += frame_body[i][SUM_W-1:0];
      send_byte(frame_body[i]);
    end
    if (kind != FRAME_STATUS_ERR) begin
      cr = CHAR_CR;
      if (kind == FRAME_NO_CR) begin
        do cr = 8'($urandom); while (cr == CHAR_CR);
      end
      sum += cr[SUM_W-1:0];
      send_byte(cr);
      sum = -sum;
      if (kind == FRAME_BAD_SUM) sum += SUM_W'($urandom_range(1, 127));
      send_byte({1'($urandom), sum});
      if (kind == FRAME_GOOD || kind == FRAME_REPEAT) prev_body = frame_body;
    end
    kind_count[kind]++;
  endtask

  // result sink: random stall patterns, plus one long hold on request
  initial begin
    int mode;
    int mode_left;
    mode = 0;
    mode_left = 0;
    out_res.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_res.valid && out_res.ready) results_seen++;
      if (long_hold_req) begin
        out_res.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_req = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 120);
        end
        mode_left--;
        case (mode)
          0: out_res.ready <= 1'b1;
          1: out_res.ready <= 1'($urandom);
          2: out_res.ready <= ($urandom_range(0, 4) == 0);
          default: out_res.ready <= mode_left[1];
        endcase
      end
    end
  end

  initial begin
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL scale_frame_parser");
    $finish;
  end

  initial begin
    int roll;
    logic pressure_done;
    frame_kind_t kind;
    pressure_done = 1'b0;
    in_rx.valid   <= 1'b0;
    in_rx.rx_byte <= 8'h00;
    rst_n         <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CHAR_CR);
    frame_body = '{8'hFF, CHAR_STX};
    transmit(FRAME_STATUS_ERR);
    frame_body = '{8'h00, 8'h11, 8'hFF,
                   CHAR_SPACE, CHAR_SPACE, CHAR_STX, 8'hFF, 8'h39, 8'h30,
                   CHAR_SPACE, CHAR_SPACE, CHAR_SPACE,
                   CHAR_SPACE, CHAR_SPACE, CHAR_SPACE};
    transmit(FRAME_GOOD);
    drain();

    while (bytes_sent < ITEMS) begin
      if (!pressure_done && bytes_sent > ITEMS / 2) begin
        // hold the sink while frames stream in back to back
        steady = 1'b1;
        long_hold_req = 1'b1;
        repeat (4) begin
          make_random_body(1'b0);
          transmit(FRAME_GOOD);
        end
        steady = 1'b0;
        drain();
        pressure_done = 1'b1;
      end
      roll = $urandom_range(0, 99);
      if (roll < 6) begin
        repeat ($urandom_range(1, 5)) send_byte(noise_byte());
      end else begin
        if (roll < 50) kind = FRAME_GOOD;
        else if (roll < 75) kind = FRAME_REPEAT;
        else if (roll < 85) kind = FRAME_BAD_SUM;
        else if (roll < 93) kind = FRAME_STATUS_ERR;
        else kind = FRAME_NO_CR;
        if (kind == FRAME_REPEAT && prev_body.size() != 0) make_repeat_body();
        else make_random_body(kind == FRAME_STATUS_ERR);
        transmit(kind);
      end
    end

    drain();
    repeat (TAIL) @(posedge clk);
    $display("Sent %0d bytes: %0d good, %0d repeated, %0d bad-checksum,",
             bytes_sent, kind_count[FRAME_GOOD], kind_count[FRAME_REPEAT],
             kind_count[FRAME_BAD_SUM]);
    $display("  %0d status-error, %0d no-CR frames",
             kind_count[FRAME_STATUS_ERR], kind_count[FRAME_NO_CR]);
    $display("Took %0d result words, %0d with good checksum, across a long sink hold",
             results_seen, good_count);
    if (fail_count == 0) begin
      $display("PASS scale_frame_parser");
    end else begin
      $display("FAIL scale_frame_parser");
    end
    $finish;
  end

endmodule
